// File: design/nlig_pkg.sv
// Shared types, constants and helper functions for the nested loop index generator.
// No dependencies; imported by every other design file.
package nlig_pkg;

  localparam int MAX_LEVELS = 8;
  localparam int VALUE_BITS = 16;
  localparam int LEVEL_BITS = $clog2(MAX_LEVELS);

  typedef logic [LEVEL_BITS-1:0]      lvl_t;
  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic signed [VALUE_BITS:0]   ext_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_NEXT  = 2'd2,
    OP_CONT  = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic start_begin;
    logic start_step;
    logic emit_begin;
    logic emit_step;
    logic emit_done;
    logic adv_begin;
    logic adv_step;
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic idx_top;
    logic idx_zero;
    logic adv_hit;
    logic out_free;
    logic cont_ok;
  } dp_stat_t;

  function automatic ext_t sext(val_t v);
    sext = {v[VALUE_BITS-1], v};
  endfunction

  function automatic logic runs(val_t step, val_t stop, ext_t v);
    ext_t stop_ext;
    stop_ext = sext(stop);
    if (step > 0) begin
      runs = (v <= stop_ext);
    end else if (step < 0) begin
      runs = (v >= stop_ext);
    end else begin
      runs = 1'b0;
    end
  endfunction

endpackage

// File: design/nlig_ctrl.sv
// Sequencing state machine for the nested loop index generator.
// Depends on nlig_pkg; drives the datapath by command and reads its status.
module nlig_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        operation,
  output nlig_pkg::dp_cmd_t cmd,
  input  nlig_pkg::dp_stat_t st
);
  import nlig_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_START    = 5'b00010,
    S_EMIT     = 5'b00100,
    S_DONE_OUT = 5'b01000,
    S_ADVANCE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(operation))
            OP_LOAD: cmd.load = 1'b1;
            OP_START: begin
              cmd.start_begin = 1'b1;
              state_next      = S_START;
            end
            OP_NEXT: begin
              if (st.finished) begin
                state_next = S_DONE_OUT;
              end else begin
                cmd.emit_begin = 1'b1;
                state_next     = S_EMIT;
              end
            end
            OP_CONT: begin
              if (!st.finished && st.cont_ok) begin
                cmd.adv_begin = 1'b1;
                state_next    = S_ADVANCE;
              end
            end
            default: ;
          endcase
        end
      end
      S_START: begin
        cmd.start_step = 1'b1;
        if (st.idx_top) state_next = S_IDLE;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit_step = 1'b1;
          if (st.idx_top) state_next = S_ADVANCE;
        end
      end
      S_DONE_OUT: begin
        if (st.out_free) begin
          cmd.emit_done = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_ADVANCE: begin
        cmd.adv_step = 1'b1;
        if (st.adv_hit || st.idx_zero) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_not_finished: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> !st.finished)
    else $error("emitting indices while finished");

  a_adv_not_finished: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADVANCE) |-> !st.finished)
    else $error("advancing while finished");

  a_done_out_finished: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE_OUT) |-> st.finished)
    else $error("done result without finished");

endmodule

// File: design/nlig_dp.sv
// Datapath: bound tables, current indices, finished flag, level counter and result register.
// Depends on nlig_pkg; commanded by nlig_ctrl.
module nlig_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_wr_data,
  input  logic [2:0]          level,
  input  logic signed [15:0]  start_value,
  input  logic signed [15:0]  stop_value,
  input  logic signed [15:0]  step_value,
  input  nlig_pkg::dp_cmd_t   cmd,
  output nlig_pkg::dp_stat_t  st,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_level,
  output logic signed [15:0]  index_value,
  output logic                last,
  output logic                done_res
);
  import nlig_pkg::*;

  val_t start_tab [MAX_LEVELS];
  val_t stop_tab  [MAX_LEVELS];
  val_t step_tab  [MAX_LEVELS];
  val_t cur       [MAX_LEVELS];
  lvl_t top_level;
  lvl_t idx;
  logic finished;
  ext_t adv_val;
  logic start_ok;

  always_comb begin
    adv_val     = sext(cur[idx]) + sext(step_tab[idx]);
    start_ok    = runs(step_tab[idx], stop_tab[idx], sext(start_tab[idx]));
    st.finished = finished;
    st.idx_top  = (idx == top_level);
    st.idx_zero = (idx == '0);
    st.adv_hit  = runs(step_tab[idx], stop_tab[idx], adv_val);
    st.out_free = !out_valid || out_ready;
    st.cont_ok  = (level <= top_level);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_level <= '0;
    end else if (cfg_wr_en) begin
      top_level <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_tab[level] <= start_value;
      stop_tab[level]  <= stop_value;
      step_tab[level]  <= step_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_LEVELS; k++) begin
        cur[k] <= '0;
      end
    end else if (cmd.start_step) begin
      cur[idx] <= start_tab[idx];
    end else if (cmd.adv_begin) begin
      for (int k = 0; k < MAX_LEVELS; k++) begin
        if (LEVEL_BITS'(k) > level && LEVEL_BITS'(k) <= top_level) begin
          cur[k] <= start_tab[k];
        end
      end
    end else if (cmd.adv_step) begin
      if (st.adv_hit) begin
        cur[idx] <= adv_val[VALUE_BITS-1:0];
      end else begin
        cur[idx] <= start_tab[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      finished <= 1'b1;
    end else begin
      if (cmd.start_begin || cmd.emit_begin) begin
        idx <= '0;
      end else if (cmd.adv_begin) begin
        idx <= level;
      end else if (cmd.start_step || cmd.emit_step) begin
        if (!st.idx_top) idx <= idx + 1'b1;
      end else if (cmd.adv_step) begin
        if (!st.adv_hit && !st.idx_zero) idx <= idx - 1'b1;
      end

      if (cmd.start_begin) begin
        finished <= 1'b0;
      end else if (cmd.start_step && !start_ok) begin
        finished <= 1'b1;
      end else if (cmd.adv_step && !st.adv_hit && st.idx_zero) begin
        finished <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_step || cmd.emit_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      out_level   <= idx;
      index_value <= cur[idx];
      last        <= st.idx_top;
      done_res    <= 1'b0;
    end else if (cmd.emit_done) begin
      out_level   <= '0;
      index_value <= '0;
      last        <= 1'b1;
      done_res    <= 1'b1;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ((cmd.emit_step || cmd.emit_done) && out_valid) |-> out_ready)
    else $error("result register overwritten before transaction");

  a_zero_step_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.start_step && step_tab[idx] == '0) |=> finished)
    else $error("zero step level did not set finished");

  a_carry_out: assert property (@(posedge clk) disable iff (rst)
    (cmd.adv_step && !st.adv_hit && st.idx_zero) |=> finished)
    else $error("outermost carry did not set finished");

endmodule

// File: design/nested_loop_index_generator_core.sv
// Nested loop index generator, top level: controller plus datapath.
// Load: writes the bounds of one level. Start: levels 0 to top_level, one level checked per cycle.
// Next: top_level+1 result transactions, one per cycle at best, then a carry ripple from
// top_level towards level 0; next when finished: a single done result.
// Continue: levels level+1 to top_level reset to their start values, then a carry ripple from level.
// Reset: finished set, top_level 0, indices zero, output empty; bound tables undefined.
module nested_loop_index_generator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [2:0]         level,
  input  logic signed [15:0] start_value,
  input  logic signed [15:0] stop_value,
  input  logic signed [15:0] step_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_level,
  output logic signed [15:0] index_value,
  output logic               last,
  output logic               done_res
);
  import nlig_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  nlig_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .cmd       (cmd),
    .st        (st)
  );

  nlig_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .level       (level),
    .start_value (start_value),
    .stop_value  (stop_value),
    .step_value  (step_value),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_level   (out_level),
    .index_value (index_value),
    .last        (last),
    .done_res    (done_res)
  );

endmodule

// File: bench/nlig_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the nested loop index generator: tracks loop bounds and indices,
// predicts every result transaction and compares it field by field. Uses nlig_pkg.
module nlig_checker
  import nlig_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [2:0]         level,
  input  logic signed [15:0] start_value,
  input  logic signed [15:0] stop_value,
  input  logic signed [15:0] step_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         out_level,
  input  logic signed [15:0] index_value,
  input  logic               last,
  input  logic               done_res,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    lvl_t lvl;
    val_t idx;
    logic is_last;
    logic is_done;
  } index_rec_t;

  val_t       first_tab [MAX_LEVELS];
  val_t       bound_tab [MAX_LEVELS];
  val_t       incr_tab  [MAX_LEVELS];
  val_t       index_now [MAX_LEVELS];
  logic       exhausted;
  lvl_t       inner;
  index_rec_t index_q [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic in_range(int lv, int v);
    if (incr_tab[lv] > 0) begin
      return v <= int'(bound_tab[lv]);
    end else if (incr_tab[lv] < 0) begin
      return v >= int'(bound_tab[lv]);
    end
    return 1'b0;
  endfunction

  function automatic void carry_from(int lv);
    int v;
    for (int k = lv + 1; k <= int'(inner); k++) begin
      index_now[k] = first_tab[k];
    end
    for (int l = lv; l >= 0; l--) begin
      v = int'(index_now[l]) + int'(incr_tab[l]);
      if (in_range(l, v)) begin
        index_now[l] = val_t'(v);
        return;
      end
      index_now[l] = first_tab[l];
    end
    exhausted = 1'b1;
  endfunction

  function automatic void predict_item(op_t op, lvl_t lv, val_t s, val_t p, val_t t);
    case (op)
      OP_LOAD: begin
        first_tab[lv] = s;
        bound_tab[lv] = p;
        incr_tab[lv] = t;
      end
      OP_START: begin
        exhausted = 1'b0;
        for (int k = 0; k <= int'(inner); k++) begin
          index_now[k] = first_tab[k];
          if (!in_range(k, int'(index_now[k]))) exhausted = 1'b1;
        end
      end
      OP_NEXT: begin
        if (exhausted) begin
          index_q.push_back('{lvl: '0, idx: '0, is_last: 1'b1, is_done: 1'b1});
        end else begin
          for (int k = 0; k <= int'(inner); k++) begin
            index_q.push_back('{lvl: lvl_t'(k), idx: index_now[k],
                                is_last: (k == int'(inner)), is_done: 1'b0});
          end
          carry_from(int'(inner));
        end
      end
      OP_CONT: begin
        if (!exhausted && lv <= inner) carry_from(int'(lv));
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    index_rec_t want;
    if (rst) begin
      for (int k = 0; k < MAX_LEVELS; k++) index_now[k] = '0;
      exhausted = 1'b1;
      inner = '0;
      index_q.delete();
    end else begin
      // check output first: a result never stems from an item taken at the same edge
      if (out_valid && out_ready) begin
        if (index_q.size() == 0) begin
          $error("unexpected result transaction: level %0d index %0d", out_level,
                 index_value);
          fail_count++;
        end else begin
          want = index_q.pop_front();
          if (out_level !== want.lvl) begin
            $error("out_level: expected %0d, actual %0d", want.lvl, out_level);
            fail_count++;
          end
          if (index_value !== want.idx) begin
            $error("index_value: expected %0d, actual %0d", want.idx, index_value);
            fail_count++;
          end
          if (last !== want.is_last) begin
            $error("last: expected %0b, actual %0b", want.is_last, last);
            fail_count++;
          end
          if (done_res !== want.is_done) begin
            $error("done_res: expected %0b, actual %0b", want.is_done, done_res);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) inner = cfg_wr_data;
      if (in_valid && in_ready) begin
        predict_item(op_t'(operation), level, start_value, stop_value, step_value);
      end
    end
    pending <= index_q.size();
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the nested loop index generator bench: clock, reset, stimulus, ready
// pressure, watchdog and verdict. Depends on nlig_pkg, nlig_checker and the core.
module tb_top;
  import nlig_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [2:0]         cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         operation = '0;
  logic [2:0]         level = '0;
  logic signed [15:0] start_value = '0;
  logic signed [15:0] stop_value = '0;
  logic signed [15:0] step_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_level;
  logic signed [15:0] index_value;
  logic               last;
  logic               done_res;

  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  bit   tx_gaps = 1'b1;
  bit   rx_stalls = 1'b1;
  bit   rx_hold_req = 1'b0;
  lvl_t depth_cfg = '0;

  always #5 clk = ~clk;

  nested_loop_index_generator_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .level       (level),
    .start_value (start_value),
    .stop_value  (stop_value),
    .step_value  (step_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_level   (out_level),
    .index_value (index_value),
    .last        (last),
    .done_res    (done_res)
  );

  nlig_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .level       (level),
    .start_value (start_value),
    .stop_value  (stop_value),
    .step_value  (step_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_level   (out_level),
    .index_value (index_value),
    .last        (last),
    .done_res    (done_res),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  task automatic send(op_t op, lvl_t lv, val_t s, val_t p, val_t t);
    int gap;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    level <= lv;
    start_value <= s;
    stop_value <= p;
    step_value <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_depth(lvl_t v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    depth_cfg = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic pick_bounds(output val_t b_first, output val_t b_bound, output val_t b_incr);
    int s;
    int d;
    int k;
    int e;
    if ($urandom_range(0, 7) == 0) begin
      b_first = val_t'($urandom);
      b_bound = val_t'($urandom);
      b_incr = val_t'($urandom);
    end else begin
      case ($urandom_range(0, 5))
        0:       s = -32768;
        1:       s = 32767;
        default: s = int'($urandom_range(0, 65535)) - 32768;
      endcase
      d = $urandom_range(1, 3);
      if ($urandom_range(0, 1) == 1) d = -d;
      if ($urandom_range(0, 15) == 0) d = 0;
      k = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(0, 1);
      e = s + d * k;
      if (e > 32767) e = 32767;
      if (e < -32768) e = -32768;
      b_first = val_t'(s);
      b_bound = val_t'(e);
      b_incr = val_t'(d);
    end
  endtask

  task automatic load_level(lvl_t lv);
    val_t f;
    val_t b;
    val_t i;
    pick_bounds(f, b, i);
    send(OP_LOAD, lv, f, b, i);
  endtask

  task automatic run_phase(bit squeeze);
    bit   saved;
    lvl_t lv;
    for (int k = 0; k <= int'(depth_cfg); k++) load_level(lvl_t'(k));
    send(OP_START, '0, '0, '0, '0);
    if (squeeze) begin
      // hold the receiver off and keep offering so the core backs up
      saved = tx_gaps;
      tx_gaps = 1'b0;
      rx_hold_req = 1'b1;
      repeat (20) send(OP_NEXT, '0, '0, '0, '0);
      tx_gaps = saved;
    end
    for (int n = 0; n < 18; n++) begin
      case ($urandom_range(0, 19))
        0: send(op_t'($urandom_range(0, 3)), lvl_t'($urandom), val_t'($urandom),
                val_t'($urandom), val_t'($urandom));
        1, 2: begin
          lv = ($urandom_range(0, 3) == 0) ? lvl_t'($urandom)
                                           : lvl_t'($urandom_range(0, depth_cfg));
          send(OP_CONT, lv, val_t'($urandom), val_t'($urandom), val_t'($urandom));
        end
        3: begin
          load_level(lvl_t'($urandom_range(0, depth_cfg)));
          send(OP_START, lvl_t'($urandom), val_t'($urandom), '0, '0);
        end
        default: send(OP_NEXT, lvl_t'($urandom), '0, '0, '0);
      endcase
    end
  endtask

  initial begin : receiver
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 14);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single level: done before any start, extreme bounds, continue handling
    send(OP_NEXT, 3'd0, '0, '0, '0);
    send(OP_CONT, 3'd0, '0, '0, '0);
    send(OP_LOAD, 3'd0, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send(OP_LOAD, 3'd1, 16'sh7FFF, 16'sh8000, 16'sh8000);
    send(OP_LOAD, 3'd2, 16'sd5, 16'sd6, 16'sd0);
    send(OP_LOAD, 3'd3, 16'sd0, 16'sd2, 16'sd1);
    send(OP_LOAD, 3'd4, 16'sd3, 16'sd1, -16'sd1);
    send(OP_LOAD, 3'd5, -16'sd1, -16'sd1, 16'sd1);
    send(OP_LOAD, 3'd6, 16'sd10, 16'sd9, 16'sd1);
    send(OP_LOAD, 3'd7, 16'sd0, 16'sd1, 16'sd1);
    send(OP_START, 3'd0, '0, '0, '0);
    send(OP_NEXT, 3'd0, '0, '0, '0);
    send(OP_CONT, 3'd1, '0, '0, '0);
    send(OP_CONT, 3'd0, '0, '0, '0);
    send(OP_NEXT, 3'd0, '0, '0, '0);
    send(OP_NEXT, 3'd0, '0, '0, '0);

    // two levels: carry past the value range, continue at each level
    settle();
    write_depth(3'd1);
    send(OP_START, 3'd0, '0, '0, '0);
    send(OP_NEXT, 3'd0, '0, '0, '0);
    send(OP_CONT, 3'd1, '0, '0, '0);
    send(OP_NEXT, 3'd0, '0, '0, '0);
    send(OP_CONT, 3'd0, '0, '0, '0);
    send(OP_NEXT, 3'd0, '0, '0, '0);

    // all levels: an empty level finishes the start at once
    settle();
    write_depth(3'd7);
    send(OP_START, 3'd0, '0, '0, '0);
    send(OP_NEXT, 3'd0, '0, '0, '0);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0, 2:    write_depth(3'd7);
        1:       write_depth(3'd0);
        default: write_depth(lvl_t'($urandom_range(0, 7)));
      endcase
      if (ph == 5) begin
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
      end
      run_phase(ph == 2);
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
